// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the grid stepper rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WWG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WWG_ASSERT(lbl, prop, msg)
`define WWG_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/wwg_pkg.sv =====
// types and codes for the wireworld grid stepper
// no dependencies
`default_nettype none
package wwg_pkg;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_HEAD  = 2'd1,
    CELL_TAIL  = 2'd2,
    CELL_WIRE  = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;
  localparam logic [6:0] CFG_RESET  = 7'd64;

  // which neighbour sides lie inside the active area
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_ok_t;

  // next state of the centre cell of the window
  typedef struct packed {
    logic [1:0] new_val;
    logic       to_head;
  } win_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wwg_cell.sv =====
// one stage of the line buffer chain, holds one cell state
// no dependencies
`default_nettype none
module wwg_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [1:0] d_i,
  output logic [1:0] q_o
);
  logic [1:0] val_q;

  // shift when the sweep runs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;
endmodule
`default_nettype wire

// ===== hw/rtl/wwg_window.sv =====
// two-row line buffer of chained cells with the wireworld update rule
// depends on wwg_pkg and wwg_cell
`default_nettype none
module wwg_window #(
  parameter int MAX_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [1:0]        data_i,
  input  wwg_pkg::nbr_ok_t  ok_i,
  output wwg_pkg::win_res_t res_o
);
  import wwg_pkg::*;

  localparam int Len = 2 * MAX_WIDTH + 3;

  logic [1:0] tap [Len];

  // chain of cells, newest cell at tap 0
  for (genvar k = 0; k < Len; k++) begin : g_chain
    if (k == 0) begin : g_head
      wwg_cell u_cell (.clk_i(clk_i), .en_i(en_i), .d_i(data_i), .q_o(tap[k]));
    end else begin : g_body
      wwg_cell u_cell (.clk_i(clk_i), .en_i(en_i), .d_i(tap[k-1]), .q_o(tap[k]));
    end
  end

  logic h_dr, h_d, h_dl, h_r, h_l, h_ur, h_u, h_ul;
  logic [3:0] cnt;
  logic [1:0] centre;

  // heads among the eight neighbours, masked at the area edge
  always_comb begin
    h_dr = ok_i.dn && ok_i.rt && (tap[0] == CELL_HEAD);
    h_d  = ok_i.dn && (tap[1] == CELL_HEAD);
    h_dl = ok_i.dn && ok_i.lf && (tap[2] == CELL_HEAD);
    h_r  = ok_i.rt && (tap[MAX_WIDTH] == CELL_HEAD);
    h_l  = ok_i.lf && (tap[MAX_WIDTH+2] == CELL_HEAD);
    h_ur = ok_i.up && ok_i.rt && (tap[2*MAX_WIDTH] == CELL_HEAD);
    h_u  = ok_i.up && (tap[2*MAX_WIDTH+1] == CELL_HEAD);
    h_ul = ok_i.up && ok_i.lf && (tap[2*MAX_WIDTH+2] == CELL_HEAD);
    cnt  = 4'(h_dr) + 4'(h_d) + 4'(h_dl) + 4'(h_r)
         + 4'(h_l) + 4'(h_ur) + 4'(h_u) + 4'(h_ul);
    centre = tap[MAX_WIDTH+1];
  end

  // next state of the centre cell
  always_comb begin
    res_o.new_val = centre;
    res_o.to_head = 1'b0;
    case (centre)
      CELL_HEAD: res_o.new_val = CELL_TAIL;
      CELL_TAIL: res_o.new_val = CELL_WIRE;
      CELL_WIRE: begin
        if (cnt == 4'd1 || cnt == 4'd2) begin
          res_o.new_val = CELL_HEAD;
          res_o.to_head = 1'b1;
        end
      end
      default: res_o.new_val = centre;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wireworld_grid_step.sv =====
// wireworld grid stepper top level: grid memory, sweep control, result register
// depends on wwg_pkg, wwg_window and assert_macros.svh
//
//  channel  | direction | signals
//  ---------+-----------+--------------------------------------------------
//  in       | input     | in_valid_i, in_ready_o, opcode, row, column, value
//  out      | output    | out_valid_o, out_ready_i, read_value, changed, count
//  cfg      | input     | cfg_we_i, cfg_index_i, cfg_data_i
//
// write and clear items are answered from the idle state; a read passes through the
// read state (registered memory read). a tick sweeps the whole grid memory:
// one memory read per cycle, the centre cell trails the read address by MAX_WIDTH + 3.
// after reset a clearing pass writes zero to every cell while no item is taken.
// one item at a time; a waiting result does not block the next item if it is taken
// in the same cycle.
`default_nettype none
`include "assert_macros.svh"
module wireworld_grid_step #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  column_i,
  input  logic [1:0]  cell_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  read_value_o,
  output logic        changed_o,
  output logic [31:0] step_count_o
);
  import wwg_pkg::*;

  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Cells);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int URW   = $clog2(MAX_HEIGHT + 1);
  localparam int UCW   = $clog2(MAX_WIDTH + 1);
  localparam int TW    = $clog2(Cells + MAX_WIDTH + 4);
  localparam int Lag   = MAX_WIDTH + 3;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_TICK  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [6:0]    act_w_q, act_h_q;
  logic [URW-1:0] urows;
  logic [UCW-1:0] ucols;
  logic [31:0]   step_q, step_d;
  logic [TW-1:0] tcnt_q, tcnt_d;
  logic [RW-1:0] crow_q, crow_d;
  logic [CW-1:0] ccol_q, ccol_d;
  logic [AW-1:0] caddr_q, caddr_d;
  logic          chg_q, chg_d;
  logic          rd_in_q, rd_in_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    rd_val_q, rd_val_d;
  logic          out_chg_q, out_chg_d;
  logic [31:0]   out_step_q, out_step_d;

  logic          accept, in_area, centre_valid, centre_act, sweep_done;
  logic [AW-1:0] item_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata, rdata_q;
  logic [1:0]    mem [Cells];
  nbr_ok_t       nbr_ok;
  win_res_t      win_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q <= CFG_RESET;
      act_h_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        act_w_q <= cfg_data_i;
      end else begin
        act_h_q <= cfg_data_i;
      end
    end
  end

  // active size limited to the grid
  always_comb begin
    urows = (32'(act_h_q) > MAX_HEIGHT) ? URW'(MAX_HEIGHT) : URW'(act_h_q);
    ucols = (32'(act_w_q) > MAX_WIDTH) ? UCW'(MAX_WIDTH) : UCW'(act_w_q);
  end

  // item decode
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_area    = (32'(row_i) < 32'(urows)) && (32'(column_i) < 32'(ucols));
  assign item_addr  = AW'(32'(row_i) * MAX_WIDTH + 32'(column_i));

  // centre position of the sweep
  assign centre_valid = (32'(tcnt_q) >= Lag);
  assign centre_act   = centre_valid && (32'(crow_q) < 32'(urows))
                      && (32'(ccol_q) < 32'(ucols));
  assign sweep_done   = centre_valid && (32'(caddr_q) == Cells - 1);

  always_comb begin
    nbr_ok.up = (crow_q != '0);
    nbr_ok.dn = (32'(crow_q) + 32'd1) < 32'(urows);
    nbr_ok.lf = (ccol_q != '0);
    nbr_ok.rt = (32'(ccol_q) + 32'd1) < 32'(ucols);
  end

  wwg_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i (clk_i),
    .en_i  (state_q == ST_TICK),
    .data_i(rdata_q),
    .ok_i  (nbr_ok),
    .res_o (win_res)
  );

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = caddr_q;
    mem_wdata = win_res.new_val;
    mem_raddr = item_addr;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_EMPTY;
      end
      ST_IDLE: begin
        mem_we    = accept && (opcode_i == OP_WRITE) && in_area;
        mem_waddr = item_addr;
        mem_wdata = cell_value_i;
      end
      ST_TICK: begin
        mem_we    = centre_act;
        mem_raddr = AW'(tcnt_q);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    tcnt_d      = tcnt_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    caddr_d     = caddr_q;
    chg_d       = chg_q;
    rd_in_d     = rd_in_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_val_d    = rd_val_q;
    out_chg_d   = out_chg_q;
    out_step_d  = out_step_q;
    case (state_q)
      ST_CLEAR: begin
        caddr_d = caddr_q + AW'(1);
        if (32'(caddr_q) == Cells - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          tcnt_d  = '0;
          crow_d  = '0;
          ccol_d  = '0;
          caddr_d = '0;
          chg_d   = 1'b0;
          rd_in_d = in_area;
          case (opcode_i)
            OP_READ: state_d = ST_RD;
            OP_TICK: state_d = ST_TICK;
            OP_CLEAR: begin
              step_d      = '0;
              out_valid_d = 1'b1;
              rd_val_d    = CELL_EMPTY;
              out_chg_d   = 1'b0;
              out_step_d  = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              rd_val_d    = CELL_EMPTY;
              out_chg_d   = 1'b0;
              out_step_d  = step_q;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        rd_val_d    = rd_in_q ? rdata_q : CELL_EMPTY;
        out_chg_d   = 1'b0;
        out_step_d  = step_q;
      end
      ST_TICK: begin
        tcnt_d = tcnt_q + TW'(1);
        if (centre_valid) begin
          caddr_d = caddr_q + AW'(1);
          chg_d   = chg_q || (centre_act && win_res.to_head);
          if (32'(ccol_q) == MAX_WIDTH - 1) begin
            ccol_d = '0;
            crow_d = crow_q + RW'(1);
          end else begin
            ccol_d = ccol_q + CW'(1);
          end
        end
        if (sweep_done) begin
          state_d     = ST_IDLE;
          step_d      = step_q + 32'd1;
          out_valid_d = 1'b1;
          rd_val_d    = CELL_EMPTY;
          out_chg_d   = chg_d;
          out_step_d  = step_q + 32'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      tcnt_q      <= '0;
      crow_q      <= '0;
      ccol_q      <= '0;
      caddr_q     <= '0;
      chg_q       <= 1'b0;
      rd_in_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      tcnt_q      <= tcnt_d;
      crow_q      <= crow_d;
      ccol_q      <= ccol_d;
      caddr_q     <= caddr_d;
      chg_q       <= chg_d;
      rd_in_q     <= rd_in_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    rd_val_q   <= rd_val_d;
    out_chg_q  <= out_chg_d;
    out_step_q <= out_step_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_val_q;
  assign changed_o    = out_chg_q;
  assign step_count_o = out_step_q;

  // checks
  `WWG_NEVER(a_no_write_in_read, (state_q == ST_RD) && mem_we, "write during read item")
  `WWG_ASSERT(a_no_result_in_clear, $rose(out_valid_q) |-> $past(state_q) != ST_CLEAR, "result during clearing pass")
  `WWG_ASSERT(a_tick_counts, (state_q == ST_TICK) && sweep_done |=> step_q == $past(step_q) + 32'd1, "tick did not count")
endmodule
`default_nettype wire
